// File: sv/assert_macros.svh
// Assertion helpers shared by the parser and emitter files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of ck while rn is high.
`define FSNF_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) else $error(msg);

// Check that cond never holds at a rising edge of ck while rn is high.
`define FSNF_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
  `FSNF_ASSERT(lbl, ck, rn, !(cond), msg)

`endif

// File: sv/fsnf_pkg.sv
`default_nettype none

package fsnf_pkg;

  localparam int SHORT_NAME_LEN = 11;
  localparam int BASE_LEN       = 8;
  localparam int BASE_EFF       = (BASE_LEN < SHORT_NAME_LEN) ? BASE_LEN : SHORT_NAME_LEN;

  // write position counts up to SHORT_NAME_LEN itself
  localparam int POS_W      = $clog2(SHORT_NAME_LEN + 1);
  localparam int OUT_IDX_W  = 4;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] SPACE = 8'h20;

  localparam logic [1:0] MODE_RELAXED = 2'd0;
  localparam logic [1:0] MODE_NORMAL  = 2'd1;
  localparam logic [1:0] MODE_STRICT  = 2'd2;

  localparam logic [1:0] REG_CHECK_MODE   = 2'd0;
  localparam logic [1:0] REG_ALT_OS_MODE  = 2'd1;
  localparam logic [1:0] REG_DOTS_ALLOWED = 2'd2;
  localparam logic [1:0] REG_KEEP_CASE    = 2'd3;

  typedef struct packed {
    logic [1:0] check_mode;
    logic       alt_os_mode;
    logic       dots_allowed;
    logic       keep_case;
  } cfg_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [OUT_IDX_W-1:0] out_index;
    logic                 status;
    logic                 hidden_mark;
    logic                 run_end;
  } out_word_t;

  // finished name handed from the parser to the emitter
  typedef struct packed {
    logic                            load;
    logic                            status;
    logic                            hidden;
    logic [SHORT_NAME_LEN-1:0][7:0]  bytes;
  } name_t;

endpackage

`default_nettype wire

// File: sv/fat_short_name_formatter.sv
// 8.3 short-name formatter.
//
// Input channel (in_valid/in_ready/in_data): one name byte per word, with
// final_byte set on the last byte of each name. Bytes are taken one per
// cycle when in_ready is high; the parser state updates on each accepted word.
// Result channel (out_valid/out_ready/out_data): on a final byte the block
// sends either eleven words (index 0 to 10, run_end on the last) holding
// the space-padded name, or a single word with status set.
// Latency: the first result word appears the cycle after the final byte.
// Throughput: one input word per cycle unless a final byte is held; one
// result word per cycle. A valid name holds the result buffer until its
// eleven words are taken, so a following final byte waits in_ready low
// until the last word of the previous name leaves (in_ready may rise in
// the cycle that word is taken). A stalled receiver holds the current
// result word; non-final bytes keep flowing into the parser meanwhile.
// Configuration goes through the APB-style port (4 registers at 4*i), to be
// written by the user only while idle, not enforced by the block. Reset
// restores normal checking and clears control state; no clearing pass is needed.

`default_nettype none

module fat_short_name_formatter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fsnf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [fsnf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [fsnf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready,
  // name byte input
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire fsnf_pkg::in_word_t                in_data,
  // short-name result
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output fsnf_pkg::out_word_t                    out_data
);

  fsnf_pkg::cfg_t  cfg;
  fsnf_pkg::name_t name;
  logic            load_ok;

  // register file: hold mode bits, answer reads
  fsnf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per-byte checks and name store; hand the finished name on final byte
  fsnf_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .load_ok  (load_ok),
    .name     (name)
  );

  // result buffer: advance one word per accepted output
  fsnf_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .name      (name),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sv/fsnf_cfg.sv
`default_nettype none

module fsnf_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [fsnf_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [fsnf_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [fsnf_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                      pready,
  output fsnf_pkg::cfg_t                            cfg
);

  fsnf_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        fsnf_pkg::REG_CHECK_MODE:   cfg_nxt.check_mode   = pwdata[1:0];
        fsnf_pkg::REG_ALT_OS_MODE:  cfg_nxt.alt_os_mode  = pwdata[0];
        fsnf_pkg::REG_DOTS_ALLOWED: cfg_nxt.dots_allowed = pwdata[0];
        fsnf_pkg::REG_KEEP_CASE:    cfg_nxt.keep_case    = pwdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fsnf_pkg::REG_CHECK_MODE:   prdata = fsnf_pkg::CFG_DATA_W'(cfg_r.check_mode);
      fsnf_pkg::REG_ALT_OS_MODE:  prdata = fsnf_pkg::CFG_DATA_W'(cfg_r.alt_os_mode);
      fsnf_pkg::REG_DOTS_ALLOWED: prdata = fsnf_pkg::CFG_DATA_W'(cfg_r.dots_allowed);
      fsnf_pkg::REG_KEEP_CASE:    prdata = fsnf_pkg::CFG_DATA_W'(cfg_r.keep_case);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_mode   <= fsnf_pkg::MODE_NORMAL;
      cfg_r.alt_os_mode  <= 1'b0;
      cfg_r.dots_allowed <= 1'b0;
      cfg_r.keep_case    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: sv/fsnf_parser.sv
`default_nettype none

`include "assert_macros.svh"

module fsnf_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fsnf_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fsnf_pkg::in_word_t in_data,
  input  wire logic               load_ok,
  output fsnf_pkg::name_t         name
);

  localparam int LEN = fsnf_pkg::SHORT_NAME_LEN;
  localparam int PW  = fsnf_pkg::POS_W;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_E5     = 8'hE5;
  localparam logic [7:0] CH_05     = 8'h05;
  localparam logic [7:0] CASE_OFFS = 8'd32;

  typedef enum logic [5:0] {
    PH_FIRST    = 6'b000001,
    PH_BASE     = 6'b000010,
    PH_NEED_DOT = 6'b000100,
    PH_SKIP     = 6'b001000,
    PH_EXT      = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_t;

  function automatic logic byte_bad(input logic [7:0] c, input fsnf_pkg::cfg_t cf);
    logic strict;
    logic special;
    strict  = (cf.check_mode == fsnf_pkg::MODE_STRICT);
    special = (c == 8'h2A) || (c == 8'h3F) || (c == 8'h3C) || (c == 8'h3E) ||
              (c == 8'h7C) || (c == 8'h22);
    byte_bad = ((cf.check_mode != fsnf_pkg::MODE_RELAXED) && special) ||
               (strict && ((c == fsnf_pkg::SPACE) ||
                           (!cf.alt_os_mode && ((c == 8'h2B) || (c == 8'h3D) ||
                                                (c == 8'h2C) || (c == 8'h3B))) ||
                           ((c >= 8'h41) && (c <= 8'h5A)))) ||
               (c < 8'd32) || (c == 8'h3A) || (c == 8'h5C);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic keep);
    if (!keep && (c >= 8'h61) && (c <= 8'h7A)) fold = c - CASE_OFFS;
    else fold = c;
  endfunction

  phase_t                ph_r, ph_nxt;
  logic [PW-1:0]         wp_r, wp_nxt;
  logic                  sp_r, sp_nxt;
  logic                  err_r, err_nxt;
  logic                  ds_r, ds_nxt;
  logic [LEN-1:0][7:0]   store_r, store_nxt;
  logic                  accept;
  logic                  fresh;

  assign in_ready = load_ok || !in_data.final_byte;
  assign accept   = in_valid && in_ready;
  assign fresh    = (wp_r == '0) && !err_r && !ds_r;

  always_comb begin
    phase_t        ph;
    logic [PW-1:0] wp;
    logic [PW-1:0] wa;
    logic [PW-1:0] pad_from;
    logic          sp, err, ds, strict, bad;
    logic          do_base, do_ext, do_enter, we, pad, fin_err;
    logic [7:0]    c, c2, wd;

    ph       = ph_r;
    wp       = wp_r;
    sp       = sp_r;
    err      = err_r;
    ds       = ds_r;
    c        = in_data.name_byte;
    c2       = c;
    strict   = (cfg.check_mode == fsnf_pkg::MODE_STRICT);
    bad      = byte_bad(c, cfg);
    do_base  = 1'b0;
    do_ext   = 1'b0;
    do_enter = 1'b0;
    we       = 1'b0;
    wa       = '0;
    wd       = '0;
    pad      = 1'b0;
    pad_from = '0;

    if (ph_r == PH_FIRST) begin
      // open a new name
      wp  = '0;
      sp  = !cfg.alt_os_mode;
      err = 1'b0;
      ds  = 1'b0;
      ph  = PH_BASE;
      if (c == CH_DOT && cfg.dots_allowed) begin
        ds = 1'b1;
      end else if (c == CH_DOT && !cfg.alt_os_mode) begin
        err = 1'b1;
      end else begin
        do_base = 1'b1;
      end
    end else if (!err_r) begin
      unique case (ph_r)
        PH_BASE: do_base = 1'b1;
        PH_NEED_DOT: begin
          if (c != CH_DOT) err = 1'b1;
          else do_enter = 1'b1;
        end
        PH_SKIP: begin
          if (c == CH_DOT) do_enter = 1'b1;
        end
        PH_EXT: do_ext = 1'b1;
        default: begin
          if (strict) err = 1'b1;
        end
      endcase
    end

    if (do_base) begin
      if (bad) begin
        err = 1'b1;
      end else begin
        c2 = (wp == '0 && c == CH_E5) ? CH_05 : c;
        if (c2 == CH_DOT) begin
          if (sp) err = 1'b1;
          do_enter = 1'b1;
        end else begin
          sp = (c2 == fsnf_pkg::SPACE);
          if (wp < PW'(LEN)) begin
            we = 1'b1;
            wa = wp;
            wd = fold(c2, cfg.keep_case);
          end
          wp = wp + PW'(1);
          if (wp >= PW'(fsnf_pkg::BASE_EFF)) begin
            if (sp) err = 1'b1;
            ph = strict ? PH_NEED_DOT : PH_SKIP;
          end
        end
      end
    end

    if (do_ext) begin
      if (bad) begin
        err = 1'b1;
      end else if (c == CH_DOT) begin
        if (strict || sp) err = 1'b1;
        ph = PH_DONE;
      end else begin
        sp = (c == fsnf_pkg::SPACE);
        if (wp < PW'(LEN)) begin
          we = 1'b1;
          wa = wp;
          wd = fold(c, cfg.keep_case);
        end
        wp = wp + PW'(1);
        if (wp >= PW'(LEN)) begin
          if (sp) err = 1'b1;
          ph = PH_DONE;
        end
      end
    end

    if (do_enter) begin
      // pad the base with spaces and move to the extension
      pad      = 1'b1;
      pad_from = wp;
      if (wp < PW'(fsnf_pkg::BASE_EFF)) wp = PW'(fsnf_pkg::BASE_EFF);
      sp = 1'b0;
      ph = (wp >= PW'(LEN)) ? PH_DONE : PH_EXT;
    end

    for (int k = 0; k < LEN; k++) begin
      if (accept && we && (wa == PW'(k))) begin
        store_nxt[k] = wd;
      end else if (accept && pad && (PW'(k) >= pad_from) &&
                   (k < fsnf_pkg::BASE_EFF)) begin
        store_nxt[k] = fsnf_pkg::SPACE;
      end else begin
        store_nxt[k] = store_r[k];
      end
    end

    fin_err = err || (((ph == PH_BASE) || (ph == PH_EXT)) && sp);

    name.load   = accept && in_data.final_byte;
    name.status = fin_err;
    name.hidden = ds && !fin_err;
    for (int k = 0; k < LEN; k++) begin
      name.bytes[k] = (PW'(k) < wp) ? store_nxt[k] : fsnf_pkg::SPACE;
    end

    if (!accept) begin
      ph_nxt  = ph_r;
      wp_nxt  = wp_r;
      sp_nxt  = sp_r;
      err_nxt = err_r;
      ds_nxt  = ds_r;
    end else if (in_data.final_byte) begin
      ph_nxt  = PH_FIRST;
      wp_nxt  = '0;
      sp_nxt  = 1'b0;
      err_nxt = 1'b0;
      ds_nxt  = 1'b0;
    end else begin
      ph_nxt  = ph;
      wp_nxt  = wp;
      sp_nxt  = sp;
      err_nxt = err;
      ds_nxt  = ds;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_FIRST;
      wp_r  <= '0;
      sp_r  <= 1'b0;
      err_r <= 1'b0;
      ds_r  <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      wp_r  <= wp_nxt;
      sp_r  <= sp_nxt;
      err_r <= err_nxt;
      ds_r  <= ds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

  `FSNF_ASSERT(a_wp_range, clk, rst_n, wp_r <= PW'(LEN), "write position past name")
  `FSNF_ASSERT(a_first_clean, clk, rst_n, (ph_r == PH_FIRST) |-> fresh, "name state not cleared")
  `FSNF_ASSERT(a_final_closes, clk, rst_n, name.load |=> (ph_r == PH_FIRST), "name left open")

endmodule

`default_nettype wire

// File: sv/fsnf_emitter.sv
`default_nettype none

`include "assert_macros.svh"

module fsnf_emitter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fsnf_pkg::name_t    name,
  output logic                    load_ok,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fsnf_pkg::out_word_t     out_data
);

  localparam int LEN = fsnf_pkg::SHORT_NAME_LEN;
  localparam int IW  = fsnf_pkg::OUT_IDX_W;

  logic                busy_r, busy_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                err_r, err_nxt;
  logic                hid_r, hid_nxt;
  logic [LEN-1:0][7:0] buf_r, buf_nxt;
  logic                last, take;

  assign last    = err_r || (idx_r == IW'(LEN - 1));
  assign take    = busy_r && out_ready;
  assign load_ok = !busy_r || (take && last);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    err_nxt  = err_r;
    hid_nxt  = hid_r;
    buf_nxt  = buf_r;
    if (name.load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      err_nxt  = name.status;
      hid_nxt  = name.hidden;
      buf_nxt  = name.bytes;
    end else if (take) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IW'(1);
        for (int k = 0; k < LEN - 1; k++) begin
          buf_nxt[k] = buf_r[k + 1];
        end
        buf_nxt[LEN-1] = fsnf_pkg::SPACE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hid_r <= hid_nxt;
    buf_r <= buf_nxt;
  end

  assign out_valid            = busy_r;
  assign out_data.out_byte    = err_r ? 8'h00 : buf_r[0];
  assign out_data.out_index   = err_r ? '0 : idx_r;
  assign out_data.status      = err_r;
  assign out_data.hidden_mark = err_r ? 1'b0 : hid_r;
  assign out_data.run_end     = last;

  `FSNF_ASSERT(a_idx_range, clk, rst_n, busy_r |-> (idx_r <= IW'(LEN - 1)), "index past name")
  `FSNF_ASSERT(a_err_single, clk, rst_n, (busy_r && err_r) |-> (idx_r == '0), "invalid not single")
  `FSNF_ASSERT(a_drain_idle, clk, rst_n, (take && last && !name.load) |=> !busy_r, "busy after last")

endmodule

`default_nettype wire
